FILE: hdl/mbe_pkg.sv
package mbe_pkg;

  // fixed field widths
  localparam int COORD_W = 10;
  localparam int FIX_W   = 32;
  localparam int CNT_W   = 16;
  localparam int GRAY_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // default geometry and queue size
  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // register indexes
  localparam logic [2:0] REG_LEFT  = 3'd0;
  localparam logic [2:0] REG_TOP   = 3'd1;
  localparam logic [2:0] REG_STEPX = 3'd2;
  localparam logic [2:0] REG_STEPY = 3'd3;
  localparam logic [2:0] REG_LIMIT = 3'd4;

  // register reset values
  localparam logic signed [FIX_W-1:0] LEFT_RST  = -32'sd536870912;
  localparam logic signed [FIX_W-1:0] TOP_RST   = -32'sd268435456;
  localparam logic signed [FIX_W-1:0] STEPX_RST = 32'sd786432;
  localparam logic signed [FIX_W-1:0] STEPY_RST = 32'sd524288;
  localparam logic [CNT_W-1:0]        LIMIT_RST = 16'd256;

  // |z|^2 bound of 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_BOUND = 64'h0400_0000_0000_0000;

  typedef struct packed {
    logic signed [FIX_W-1:0] left_edge;
    logic signed [FIX_W-1:0] top_edge;
    logic signed [FIX_W-1:0] step_x;
    logic signed [FIX_W-1:0] step_y;
  } cfg_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] c_re;
    logic signed [FIX_W-1:0] c_im;
  } point_t;

  // clamp a wide signed value into the Q4.28 range
  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[FIX_W-1:0];
    end
  endfunction

  // largest g with 256*g*g <= 65025*n, for n below 256
  function automatic logic [255:0][GRAY_W-1:0] gray_lut_build();
    logic [255:0][GRAY_W-1:0] lut;
    int unsigned g_best;
    for (int n = 0; n < 256; n++) begin
      g_best = 0;
      for (int g = 1; g < 256; g++) begin
        if (256 * g * g <= 65025 * n) begin
          g_best = g;
        end
      end
      lut[n] = GRAY_W'(g_best);
    end
    return lut;
  endfunction

  localparam logic [255:0][GRAY_W-1:0] GRAY_LUT = gray_lut_build();

endpackage

FILE: hdl/mbe_in_if.sv
interface mbe_in_if;
  import mbe_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

FILE: hdl/mbe_out_if.sv
interface mbe_out_if;
  import mbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  escape_count;
  logic [GRAY_W-1:0] gray_level;

  modport source (output valid, output escape_count, output gray_level, input ready);
  modport sink (input valid, input escape_count, input gray_level, output ready);
endinterface

FILE: hdl/mandelbrot_escape_time.sv
// a pixel passes the front (capture, offset multiply, push), the point queue, then the
// core, which alternates a multiply state and an escape-test/update state until the
// orbit escapes or the limit is reached; a zero limit skips the iteration loop
// the core takes a new point only once the last result is in the result register; the
// front takes a new pixel once its point is pushed, and overlaps with the core through the queue
// reset: synchronous active-low rst_n clears control and loads register defaults
module mandelbrot_escape_time #(
  parameter int IMAGE_WIDTH  = mbe_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = mbe_pkg::IMAGE_HEIGHT_DEF,
  parameter int QUEUE_DEPTH  = mbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mbe_in_if.sink                     in_ch,
  mbe_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0] paddr,
  input  logic [mbe_pkg::DATA_W-1:0] pwdata,
  output logic [mbe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import mbe_pkg::*;

  cfg_t             cfg_r;
  logic [CNT_W-1:0] limit_r;
  logic             wr_en;
  logic [2:0]       reg_idx;
  point_t           f_pt, q_pt;
  logic             f_valid, f_ready, q_valid, q_ready;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_edge <= LEFT_RST;
      cfg_r.top_edge  <= TOP_RST;
      cfg_r.step_x    <= STEPX_RST;
      cfg_r.step_y    <= STEPY_RST;
      limit_r         <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT:  cfg_r.left_edge <= $signed(pwdata);
        REG_TOP:   cfg_r.top_edge  <= $signed(pwdata);
        REG_STEPX: cfg_r.step_x    <= $signed(pwdata);
        REG_STEPY: cfg_r.step_y    <= $signed(pwdata);
        REG_LIMIT: limit_r         <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_LEFT:  prdata = cfg_r.left_edge;
      REG_TOP:   prdata = cfg_r.top_edge;
      REG_STEPX: prdata = cfg_r.step_x;
      REG_STEPY: prdata = cfg_r.step_y;
      REG_LIMIT: prdata = DATA_W'(limit_r);
      default:   prdata = '0;
    endcase
  end

  // front: pixel to point
  mbe_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .in_ch      (in_ch),
    .pt_o       (f_pt),
    .pt_valid_o (f_valid),
    .pt_ready_i (f_ready)
  );

  // point queue between front and core
  mbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_data_i  (f_pt),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_pt),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  // core: orbit iteration and shading
  mbe_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .limit_i    (limit_r),
    .pt_i       (q_pt),
    .pt_valid_i (q_valid),
    .pt_ready_o (q_ready),
    .out_ch     (out_ch)
  );

endmodule

FILE: hdl/mbe_front.sv
module mbe_front #(
  parameter int IMAGE_WIDTH  = mbe_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = mbe_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mbe_pkg::cfg_t   cfg_i,
  mbe_in_if.sink          in_ch,
  output mbe_pkg::point_t pt_o,
  output logic            pt_valid_o,
  input  logic            pt_ready_i
);
  import mbe_pkg::*;

  localparam int COL_MAX = (IMAGE_WIDTH - 1 > (1 << COORD_W) - 1) ?
                           (1 << COORD_W) - 1 : IMAGE_WIDTH - 1;
  localparam int ROW_MAX = (IMAGE_HEIGHT - 1 > (1 << COORD_W) - 1) ?
                           (1 << COORD_W) - 1 : IMAGE_HEIGHT - 1;
  localparam int PROD_W  = FIX_W + COORD_W + 1;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [COORD_W-1:0]       col_r, row_r;
  logic [COORD_W-1:0]       col_c, row_c;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic signed [COORD_W:0]  col_s, row_s;
  logic signed [63:0]       sum_re, sum_im;

  assign in_ch.ready = (state_r == F_IDLE);

  // clamp pixels outside the image to its last column and row
  assign col_c = (in_ch.column > COORD_W'(COL_MAX)) ? COORD_W'(COL_MAX) : in_ch.column;
  assign row_c = (in_ch.row > COORD_W'(ROW_MAX)) ? COORD_W'(ROW_MAX) : in_ch.row;

  assign col_s = $signed({1'b0, col_r});
  assign row_s = $signed({1'b0, row_r});

  // edge plus offset, saturated to Q4.28
  assign sum_re = 64'(cfg_i.left_edge) + 64'(px_r);
  assign sum_im = 64'(cfg_i.top_edge) + 64'(py_r);

  assign pt_o.c_re  = sat32(sum_re);
  assign pt_o.c_im  = sat32(sum_im);
  assign pt_valid_o = (state_r == F_PUSH);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_ch.valid) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_PUSH;
      F_PUSH: if (pt_ready_i) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pixel capture and offset products
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_ch.valid) begin
      col_r <= col_c;
      row_r <= row_c;
    end
    if (state_r == F_MUL) begin
      px_r <= col_s * cfg_i.step_x;
      py_r <= row_s * cfg_i.step_y;
    end
  end

endmodule

FILE: hdl/mbe_queue.sv
module mbe_queue #(
  parameter int DEPTH = mbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mbe_pkg::point_t push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output mbe_pkg::point_t pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);
  import mbe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  point_t              mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]   fill_r;
  logic                push, pop;

  assign push_ready_o = (fill_r != CNT_QW'(DEPTH));
  assign pop_valid_o  = (fill_r != '0);
  assign pop_data_o   = mem_r[rd_ptr_r];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/mbe_core.sv
module mbe_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mbe_pkg::CNT_W-1:0] limit_i,
  input  mbe_pkg::point_t           pt_i,
  input  logic                      pt_valid_i,
  output logic                      pt_ready_o,
  mbe_out_if.source                 out_ch
);
  import mbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic signed [FIX_W-1:0] c_re_r, c_im_r, z_re_r, z_im_r;
  logic signed [63:0]      rr_r, ii_r, ri_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_inc;
  logic                    out_valid_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [GRAY_W-1:0]       out_gray_r;
  logic [63:0]             mag;
  logic                    escaped;
  logic signed [63:0]      diff, re_sum, im_sum;
  logic                    load, emit, slot_free;
  logic [GRAY_W-1:0]       gray;

  assign pt_ready_o = (state_r == ST_IDLE);
  assign load       = pt_ready_o && pt_valid_i;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign emit       = (state_r == ST_DONE) && slot_free;

  // escape test and next z from the registered products
  assign mag       = $unsigned(rr_r) + $unsigned(ii_r);
  assign escaped   = (mag > ESCAPE_BOUND);
  assign diff      = rr_r - ii_r;
  assign re_sum    = (diff >>> 28) + 64'(c_re_r);
  assign im_sum    = (ri_r >>> 27) + 64'(c_im_r);
  assign count_inc = count_r + 1'b1;

  // shade from the count, saturated past 255
  assign gray = (count_r[CNT_W-1:8] != '0) ? GRAY_W'(255) : GRAY_LUT[count_r[7:0]];

  // iteration sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pt_valid_i) state_nxt = (limit_i == '0) ? ST_DONE : ST_MUL;
      ST_MUL:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (escaped || count_inc == limit_i) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        count_r <= '0;
      end else if (state_r == ST_EVAL && !escaped) begin
        count_r <= count_inc;
      end
    end
  end

  // point and orbit registers
  always_ff @(posedge clk) begin
    if (load) begin
      c_re_r <= pt_i.c_re;
      c_im_r <= pt_i.c_im;
      z_re_r <= pt_i.c_re;
      z_im_r <= pt_i.c_im;
    end else if (state_r == ST_EVAL && !escaped) begin
      z_re_r <= sat32(re_sum);
      z_im_r <= sat32(im_sum);
    end
    if (state_r == ST_MUL) begin
      rr_r <= z_re_r * z_re_r;
      ii_r <= z_im_r * z_im_r;
      ri_r <= z_re_r * z_im_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_count_r <= count_r;
      out_gray_r  <= gray;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.escape_count = out_count_r;
  assign out_ch.gray_level   = out_gray_r;

  // count stays within the limit while a pixel is in flight
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (count_r <= limit_i))
    else $error("iteration count past limit");

  // products are always evaluated in the next cycle
  a_mul_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_EVAL))
    else $error("multiply not followed by evaluate");

  // a finished pixel always lands in the result register
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result lost on emit");

  // shade saturates for long orbits
  a_gray_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r[CNT_W-1:8] != '0) |-> (out_gray_r == GRAY_W'(255)))
    else $error("gray level not saturated");

endmodule
